>>> hdl/rsw_pkg.sv
// shared types, field widths and operation codes for the ring stack
`default_nettype none

package rsw_pkg;

	localparam int MAX_DEPTH_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int FUNC_W  = 2;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;
	localparam int INDEX_W = 4;

	localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [WORD_W-1:0]  push_data;
		logic               overwrite;
		logic [INDEX_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [WORD_W-1:0]  read_data;
		logic [COUNT_W-1:0] held_now;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/rsw_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module rsw_ram #(
	parameter int WIDTH = rsw_pkg::DATA_WIDTH_DEF,
	parameter int DEPTH = rsw_pkg::MAX_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/rsw_ctrl.sv
// controller: clearing pass, request acceptance and response register handshake
`default_nettype none

module rsw_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsw_pkg::dp_cmd_t      cmd,
	input  wire rsw_pkg::dp_sts_t sts
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   can_take;
	logic   accept;

	assign can_take  = (state_q == ST_IDLE) && (!rsp_valid_q || !rsp_stall);
	assign accept    = req_valid && can_take;
	assign req_stall = !can_take;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.accept = accept;
		cmd.load   = (state_q == ST_RESP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/rsw_dp.sv
// datapath: pointers, held count, capacity register, entry store and response register
`default_nettype none

module rsw_dp #(
	parameter int MAX_DEPTH  = rsw_pkg::MAX_DEPTH_DEF,
	parameter int DATA_WIDTH = rsw_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rsw_pkg::dp_cmd_t            cmd,
	output rsw_pkg::dp_sts_t                 sts,
	input  wire rsw_pkg::req_t               req,
	output rsw_pkg::rsp_t                    rsp,
	input  wire logic                        cfg_we,
	input  wire logic [rsw_pkg::COUNT_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int PTR_W = $clog2(MAX_DEPTH);
	localparam int SUM_W = ((CNT_W > rsw_pkg::INDEX_W) ? CNT_W : rsw_pkg::INDEX_W) + 1;

	logic [CNT_W-1:0] cap_q;
	logic [PTR_W-1:0] top_q;
	logic [CNT_W-1:0] held_q;
	logic [PTR_W-1:0] clr_q;

	logic             ok_s1;
	logic             use_rd_s1;
	logic [CNT_W-1:0] held_s1;
	logic             empty_s1;
	logic             full_s1;
	rsw_pkg::rsp_t    rsp_q;

	logic [CNT_W-1:0] cap_clamp;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] top_inc;
	logic [PTR_W-1:0] top_push;
	logic [CNT_W-1:0] cap_m1;
	logic [PTR_W-1:0] top_pop;
	logic [SUM_W-1:0] ridx_w;
	logic [SUM_W-1:0] cap_w;
	logic             idx_ok;
	logic [SUM_W-1:0] first_raw;
	logic [SUM_W-1:0] first_slot;
	logic [SUM_W-1:0] pos_raw;
	logic [SUM_W-1:0] pos;

	logic             ok;
	logic             use_rd;
	logic [CNT_W-1:0] held_nx;
	logic [PTR_W-1:0] top_nx;

	logic                  ram_we;
	logic [PTR_W-1:0]      ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [PTR_W-1:0]      ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// capacity clamp into 1 .. MAX_DEPTH
	always_comb begin
		if (cfg_data == '0) begin
			cap_clamp = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_DEPTH)) begin
			cap_clamp = CNT_W'(MAX_DEPTH);
		end else begin
			cap_clamp = CNT_W'(cfg_data);
		end
	end

	assign full  = (held_q >= cap_q);
	assign empty = (held_q == '0);

	assign top_inc  = CNT_W'(top_q) + CNT_W'(1);
	assign top_push = (top_inc >= cap_q) ? '0 : top_inc[PTR_W-1:0];
	assign cap_m1   = cap_q - CNT_W'(1);
	assign top_pop  = (top_q == '0) ? cap_m1[PTR_W-1:0] : top_q - PTR_W'(1);

	// position counted from the oldest entry, wrapped twice at most
	assign ridx_w     = SUM_W'(req.read_index);
	assign cap_w      = SUM_W'(cap_q);
	assign idx_ok     = (ridx_w < cap_w);
	assign first_raw  = SUM_W'(top_q) + cap_w - SUM_W'(held_q);
	assign first_slot = (first_raw >= cap_w) ? first_raw - cap_w : first_raw;
	assign pos_raw    = first_slot + ridx_w;
	assign pos        = (pos_raw >= cap_w) ? pos_raw - cap_w : pos_raw;

	always_comb begin
		ok        = 1'b0;
		use_rd    = 1'b0;
		held_nx   = held_q;
		top_nx    = top_q;
		ram_we    = 1'b0;
		ram_waddr = top_q;
		ram_wdata = DATA_WIDTH'(req.push_data);
		ram_raddr = top_pop;
		case (req.func)
			rsw_pkg::FUNC_PUSH: begin
				ok = !full || req.overwrite;
				if (ok) begin
					ram_we  = cmd.accept;
					held_nx = full ? held_q : held_q + CNT_W'(1);
					top_nx  = top_push;
				end
			end
			rsw_pkg::FUNC_POP: begin
				ok     = !empty;
				use_rd = ok;
				if (ok) begin
					held_nx = held_q - CNT_W'(1);
					top_nx  = top_pop;
				end
			end
			rsw_pkg::FUNC_READ: begin
				ok        = idx_ok;
				use_rd    = ok;
				ram_raddr = pos[PTR_W-1:0];
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CNT_W'(MAX_DEPTH);
			top_q  <= '0;
			held_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + PTR_W'(1);
			end
			if (cfg_we && empty) begin
				cap_q <= cap_clamp;
				top_q <= '0;
			end else if (cmd.accept) begin
				held_q <= held_nx;
				top_q  <= top_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ok_s1     <= ok;
			use_rd_s1 <= use_rd;
			held_s1   <= held_nx;
			empty_s1  <= (held_nx == '0);
			full_s1   <= (held_nx >= cap_q);
		end
		if (cmd.load) begin
			rsp_q.ok        <= ok_s1;
			rsp_q.read_data <= use_rd_s1 ? rsw_pkg::WORD_W'(ram_rdata) : '0;
			rsp_q.held_now  <= rsw_pkg::COUNT_W'(held_s1);
			rsp_q.is_empty  <= empty_s1;
			rsp_q.is_full   <= full_s1;
		end
	end

	assign rsp            = rsp_q;
	assign sts.clear_last = (clr_q == PTR_W'(MAX_DEPTH - 1));

	rsw_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(MAX_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

`default_nettype wire

>>> hdl/ring_stack_with_overwrite_core.sv
// top level of the circular last-in-first-out stack with overwrite of the oldest entry
//
// Each request is a push, a pop or a read at an index counted from the oldest entry, and
// gives exactly one response carrying ok, the read word, the held count and the empty and
// full flags. A request first updates the pointers and addresses the entry store, then the
// store's registered read is loaded into the response register; the controller sets this,
// so no new request is accepted before the last one's response is registered, nor while
// a waiting response is stalled. After reset the store is cleared to zero, one entry a cycle,
// and no request is accepted until every entry is cleared; capacity writes are taken
// at any time but only change the capacity while the stack is empty.
`default_nettype none

module ring_stack_with_overwrite_core #(
	parameter int MAX_DEPTH  = rsw_pkg::MAX_DEPTH_DEF,
	parameter int DATA_WIDTH = rsw_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire rsw_pkg::req_t               req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output rsw_pkg::rsp_t                    rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [rsw_pkg::COUNT_W-1:0] cfg_data
);

	rsw_pkg::dp_cmd_t cmd;
	rsw_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	rsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	rsw_dp #(
		.MAX_DEPTH (MAX_DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.req     (req),
		.rsp     (rsp),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data)
	);

endmodule

`default_nettype wire
